/* rtl/msp2fr_pkg.sv */
`default_nettype none

package msp2fr_pkg;

  // Header bytes of an MSP v2 frame towards the receiver.
  localparam logic [7:0] HdrStart = 8'h24;  // '$'
  localparam logic [7:0] HdrProto = 8'h58;  // 'X'
  localparam logic [7:0] HdrDir   = 8'h3E;  // '>'

  // CRC-8 DVB-S2 generator polynomial.
  localparam logic [7:0] CrcPoly = 8'hD5;

  // Configuration register indexes.
  localparam logic [3:0] RegTimeoutTicks = 4'd0;
  localparam logic [3:0] RegMaxPayload   = 4'd1;
  localparam logic [3:0] RegExpectedId   = 4'd2;
  localparam logic [3:0] RegIdFilterOn   = 4'd3;

  // Receiver phases.
  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_X     = 4'd1,
    PH_DIR   = 4'd2,
    PH_FLAG  = 4'd3,
    PH_ID_LO = 4'd4,
    PH_ID_HI = 4'd5,
    PH_SZ_LO = 4'd6,
    PH_SZ_HI = 4'd7,
    PH_DATA  = 4'd8,
    PH_CRC   = 4'd9
  } phase_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD_CRC = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_e;

  // One result item as it travels to the output port.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_id;
    logic [15:0] frame_size;
    logic [7:0]  frame_flags;
    logic        truncated;
    logic        last;
  } result_t;

  // One byte step of CRC-8 DVB-S2, most significant bit first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/msp2fr_skid.sv */
`default_nettype none

// Two-entry output stage: an output register and a skid register behind it.
module msp2fr_skid (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      push_i,
  input  wire msp2fr_pkg::result_t push_data_i,
  output logic                     full_o,
  output logic                     out_valid_o,
  output msp2fr_pkg::result_t      out_data_o,
  input  wire                      out_stall_i
);

  logic                out_valid_q;
  logic                skid_valid_q;
  msp2fr_pkg::result_t out_data_q;
  msp2fr_pkg::result_t skid_data_q;
  logic                take;

  // The output transaction completes when the held result is not stalled.
  assign take = out_valid_q & ~out_stall_i;

  // Valid flags of both entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload of both entries; no reset needed.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_data_q <= push_data_i;
      end else begin
        skid_data_q <= push_data_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* rtl/msp_v2_frame_receiver_top.sv */
`default_nettype none

// MSP v2 frame receiver with CRC-8 DVB-S2 check.
// A result is registered in the output register, or in the skid register while the output register is stalled.
// Throughput: one input item per cycle; the byte-wide CRC update and phase logic finish
// in the accepting cycle. Input stalls only while both output entries are occupied.
// Reset (asynchronous, active low) returns to header hunting, clears the receiver state
// and restores the register defaults (max_payload all ones, the others zero).
module msp_v2_frame_receiver_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         action_i,
  input  wire  [7:0]  rx_byte_i,
  // Output channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] byte_index_o,
  output logic [15:0] frame_id_o,
  output logic [15:0] frame_size_o,
  output logic [7:0]  frame_flags_o,
  output logic        truncated_o,
  output logic        last_o,
  // Configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);

  // Configuration registers
  logic [31:0] timeout_ticks_q;
  logic [15:0] max_payload_q;
  logic [15:0] expected_id_q;
  logic        id_filter_on_q;

  // Receiver state
  msp2fr_pkg::phase_e phase_q, phase_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] held_id_q, held_id_d;
  logic [7:0]  held_flags_q, held_flags_d;
  logic [15:0] held_size_q, held_size_d;
  logic [15:0] count_q, count_d;
  logic [31:0] ticks_q, ticks_d;

  logic                in_accept;
  logic                is_byte;
  logic                is_tick;
  logic [31:0]         ticks_inc;
  logic                timeout_hit;
  logic                header_bad_start;
  logic [15:0]         count_inc;
  logic                frame_passes;
  logic                res_valid;
  msp2fr_pkg::result_t res;
  msp2fr_pkg::result_t out_data;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign is_tick     = in_accept & action_i;
  assign is_byte     = in_accept & ~action_i;

  // Saturating tick counter and timeout compare.
  assign ticks_inc   = (ticks_q == '1) ? ticks_q : ticks_q + 32'd1;
  assign timeout_hit = (timeout_ticks_q != '0) && (ticks_inc >= timeout_ticks_q);

  assign header_bad_start = (rx_byte_i == msp2fr_pkg::HdrStart);
  assign count_inc        = count_q + 16'd1;
  assign frame_passes     = !(id_filter_on_q && (held_id_q != expected_id_q));

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= '0;
      max_payload_q   <= '1;
      expected_id_q   <= '0;
      id_filter_on_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        msp2fr_pkg::RegTimeoutTicks: timeout_ticks_q <= cfg_data_i;
        msp2fr_pkg::RegMaxPayload:   max_payload_q   <= cfg_data_i[15:0];
        msp2fr_pkg::RegExpectedId:   expected_id_q   <= cfg_data_i[15:0];
        msp2fr_pkg::RegIdFilterOn:   id_filter_on_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (is_tick) begin
      if (timeout_hit) begin
        phase_d = msp2fr_pkg::PH_HUNT;
      end
    end else if (is_byte) begin
      case (phase_q)
        msp2fr_pkg::PH_HUNT: begin
          phase_d = header_bad_start ? msp2fr_pkg::PH_X : msp2fr_pkg::PH_HUNT;
        end
        msp2fr_pkg::PH_X: begin
          if (rx_byte_i == msp2fr_pkg::HdrProto) begin
            phase_d = msp2fr_pkg::PH_DIR;
          end else begin
            phase_d = header_bad_start ? msp2fr_pkg::PH_X : msp2fr_pkg::PH_HUNT;
          end
        end
        msp2fr_pkg::PH_DIR: begin
          if (rx_byte_i == msp2fr_pkg::HdrDir) begin
            phase_d = msp2fr_pkg::PH_FLAG;
          end else begin
            phase_d = header_bad_start ? msp2fr_pkg::PH_X : msp2fr_pkg::PH_HUNT;
          end
        end
        msp2fr_pkg::PH_FLAG:  phase_d = msp2fr_pkg::PH_ID_LO;
        msp2fr_pkg::PH_ID_LO: phase_d = msp2fr_pkg::PH_ID_HI;
        msp2fr_pkg::PH_ID_HI: phase_d = msp2fr_pkg::PH_SZ_LO;
        msp2fr_pkg::PH_SZ_LO: phase_d = msp2fr_pkg::PH_SZ_HI;
        msp2fr_pkg::PH_SZ_HI: begin
          phase_d = ({rx_byte_i, held_size_q[7:0]} == 16'd0) ?
                    msp2fr_pkg::PH_CRC : msp2fr_pkg::PH_DATA;
        end
        msp2fr_pkg::PH_DATA: begin
          phase_d = (count_inc >= held_size_q) ? msp2fr_pkg::PH_CRC : msp2fr_pkg::PH_DATA;
        end
        msp2fr_pkg::PH_CRC: phase_d = msp2fr_pkg::PH_HUNT;
        default:            phase_d = msp2fr_pkg::PH_HUNT;
      endcase
    end
  end

  // Header fields, checksum, counters and the result of this transaction.
  always_comb begin
    crc_d        = crc_q;
    held_id_d    = held_id_q;
    held_flags_d = held_flags_q;
    held_size_d  = held_size_q;
    count_d      = count_q;
    ticks_d      = ticks_q;
    res_valid    = 1'b0;

    res              = '0;
    res.frame_id     = held_id_q;
    res.frame_size   = held_size_q;
    res.frame_flags  = held_flags_q;
    res.truncated    = (held_size_q > max_payload_q);

    if (is_tick) begin
      ticks_d = ticks_inc;
      if (timeout_hit) begin
        ticks_d   = '0;
        res_valid = 1'b1;
        res       = '0;
        res.kind  = msp2fr_pkg::KIND_TIMEOUT;
        res.last  = 1'b1;
      end
    end else if (is_byte) begin
      case (phase_q)
        msp2fr_pkg::PH_FLAG: begin
          held_flags_d = rx_byte_i;
          crc_d        = msp2fr_pkg::crc8_update(8'd0, rx_byte_i);
        end
        msp2fr_pkg::PH_ID_LO: begin
          held_id_d = {8'd0, rx_byte_i};
          crc_d     = msp2fr_pkg::crc8_update(crc_q, rx_byte_i);
        end
        msp2fr_pkg::PH_ID_HI: begin
          held_id_d = {rx_byte_i, held_id_q[7:0]};
          crc_d     = msp2fr_pkg::crc8_update(crc_q, rx_byte_i);
        end
        msp2fr_pkg::PH_SZ_LO: begin
          held_size_d = {8'd0, rx_byte_i};
          crc_d       = msp2fr_pkg::crc8_update(crc_q, rx_byte_i);
        end
        msp2fr_pkg::PH_SZ_HI: begin
          held_size_d = {rx_byte_i, held_size_q[7:0]};
          crc_d       = msp2fr_pkg::crc8_update(crc_q, rx_byte_i);
          count_d     = '0;
        end
        msp2fr_pkg::PH_DATA: begin
          crc_d   = msp2fr_pkg::crc8_update(crc_q, rx_byte_i);
          count_d = count_inc;
          if ((count_q < max_payload_q) && frame_passes) begin
            res_valid        = 1'b1;
            res.kind         = msp2fr_pkg::KIND_PAYLOAD;
            res.payload_byte = rx_byte_i;
            res.byte_index   = count_q;
          end
        end
        msp2fr_pkg::PH_CRC: begin
          ticks_d = '0;
          if (frame_passes) begin
            res_valid = 1'b1;
            res.kind  = (rx_byte_i == crc_q) ? msp2fr_pkg::KIND_GOOD :
                                               msp2fr_pkg::KIND_BAD_CRC;
            res.last  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= msp2fr_pkg::PH_HUNT;
      crc_q        <= '0;
      held_id_q    <= '0;
      held_flags_q <= '0;
      held_size_q  <= '0;
      count_q      <= '0;
      ticks_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      crc_q        <= crc_d;
      held_id_q    <= held_id_d;
      held_flags_q <= held_flags_d;
      held_size_q  <= held_size_d;
      count_q      <= count_d;
      ticks_q      <= ticks_d;
    end
  end

  // Output register with skid entry.
  msp2fr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .out_stall_i (out_stall_i)
  );

  assign kind_o         = out_data.kind;
  assign payload_byte_o = out_data.payload_byte;
  assign byte_index_o   = out_data.byte_index;
  assign frame_id_o     = out_data.frame_id;
  assign frame_size_o   = out_data.frame_size;
  assign frame_flags_o  = out_data.frame_flags;
  assign truncated_o    = out_data.truncated;
  assign last_o         = out_data.last;

  // The input only stalls while a result is held in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

  // A payload byte never closes a run, and every other kind does.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o != msp2fr_pkg::KIND_PAYLOAD)))
    else $error("last flag does not match result kind");

  // A timeout returns to hunting with a cleared tick count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_tick && timeout_hit) |=> (phase_q == msp2fr_pkg::PH_HUNT) && (ticks_q == '0))
    else $error("timeout did not restart the hunt");

  // The checksum byte ends the frame and clears the tick count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_byte && (phase_q == msp2fr_pkg::PH_CRC)) |=>
      (phase_q == msp2fr_pkg::PH_HUNT) && (ticks_q == '0))
    else $error("checksum byte did not end the frame");

endmodule

`default_nettype wire
